>>> sv/ssidl_pkg.sv
package ssidl_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int SSID_BYTES      = 32;
    localparam int SSID_POS_W      = 5;

    localparam logic [47:0] BSSID_BCAST = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_READ   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    localparam logic [3:0] ST_IGNORED    = 4'd0;
    localparam logic [3:0] ST_BAD_SUB    = 4'd1;
    localparam logic [3:0] ST_NO_SSID    = 4'd2;
    localparam logic [3:0] ST_BROADCAST  = 4'd3;
    localparam logic [3:0] ST_KNOWN      = 4'd4;
    localparam logic [3:0] ST_FULL       = 4'd5;
    localparam logic [3:0] ST_STORED     = 4'd6;
    localparam logic [3:0] ST_READ_OK    = 4'd7;
    localparam logic [3:0] ST_BAD_INDEX  = 4'd8;
    localparam logic [3:0] ST_REMOVED    = 4'd9;
    localparam logic [3:0] ST_REM_BAD    = 4'd10;
    localparam logic [3:0] ST_CLEARED    = 4'd11;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_TAG       = 3'd1,
        PH_SSID_LEN  = 3'd2,
        PH_SKIP_LEN  = 3'd3,
        PH_SKIP_BODY = 3'd4,
        PH_SSID_BODY = 3'd5,
        PH_FOUND     = 3'd6,
        PH_STOP      = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        B_IDLE     = 3'd0,
        B_SEARCH   = 3'd1,
        B_COPY     = 3'd2,
        B_RD_WAIT  = 3'd3,
        B_SHIFT_RD = 3'd4,
        B_SHIFT_WR = 3'd5,
        B_EMIT     = 3'd6
    } bstate_t;

    // request passed from the parser to the table engine
    typedef struct packed {
        op_t         op;
        logic        found;
        logic [3:0]  status;
        logic [47:0] bssid;
        logic [5:0]  slen;
        logic [3:0]  idx;
        logic [4:0]  pos;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  idx;
        logic [47:0] bssid;
        logic [5:0]  slen;
        logic [7:0]  sbyte;
    } res_t;

    // accepted management subtypes
    function automatic logic subtype_ok(logic [7:0] fc);
        logic [3:0] st;
        st = fc[7:4];
        return (st == 4'h5) || (st == 4'h8) || (st == 4'h0) || (st == 4'h2);
    endfunction

    function automatic logic [4:0] fixed_len(logic [7:0] fc);
        logic [4:0] r;
        unique case (fc[7:4])
            4'h5, 4'h8: r = 5'd12;
            4'h0:       r = 5'd4;
            4'h2:       r = 5'd10;
            default:    r = 5'd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/ssidl_front.sv
module ssidl_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  ssidl_pkg::op_t        op,
    input  logic [7:0]            data_byte,
    input  logic                  frame_last,
    input  logic [3:0]            entry_index,
    input  logic [4:0]            ssid_position,
    output logic                  cmd_push,
    output ssidl_pkg::cmd_t       cmd,
    input  logic [4:0]            cap_idx,
    output logic [7:0]            cap_byte
);
    import ssidl_pkg::*;

    logic [11:0] bpos_reg, bpos_next;
    logic [7:0]  fc_reg, fc_next;
    logic [47:0] bssid_reg, bssid_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  ebl_reg, ebl_next;
    logic [5:0]  slen_reg, slen_next;
    logic [7:0]  cap_mem [SSID_BYTES];

    logic        cap_we;
    logic [4:0]  cap_wi;
    logic        first;
    phase_t      ph;
    logic [12:0] hdr_end;
    logic        ok;
    logic [5:0]  k;
    logic [7:0]  ebl_b;
    logic [5:0]  slen_b;
    logic        is_frame;

    // phase as it stands after this byte, before the frame-end reset
    function automatic phase_t phase_reg_after();
        phase_t r;
        r = ph;
        unique case (ph)
            PH_HEADER:    r = ({1'b0, bpos_reg} + 13'd1 >= hdr_end) ?
                              (ok ? PH_TAG : PH_STOP) : PH_HEADER;
            PH_SSID_BODY: r = (k == 6'd0 && data_byte == 8'd0) ? PH_STOP :
                              ((ebl_b - 8'd1) == 8'd0 ? PH_FOUND : PH_SSID_BODY);
            PH_TAG:       r = (data_byte == 8'd0) ? PH_SSID_LEN : PH_SKIP_LEN;
            PH_SKIP_LEN:  r = (data_byte == 8'd0) ? PH_TAG : PH_SKIP_BODY;
            PH_SKIP_BODY: r = ((ebl_b - 8'd1) == 8'd0) ? PH_TAG : PH_SKIP_BODY;
            PH_SSID_LEN:  r = (data_byte == 8'd0 || data_byte > 8'd32) ?
                              PH_STOP : PH_SSID_BODY;
            default:      r = ph;
        endcase
        return r;
    endfunction

    function automatic logic [12:0] bpos_after();
        return (bpos_reg < 12'd4095) ? {1'b0, bpos_reg} + 13'd1 : {1'b0, bpos_reg};
    endfunction

    assign is_frame = accept && (op == OP_FRAME);

    // parse one frame byte
    always_comb
    begin
        bpos_next  = bpos_reg;
        fc_next    = fc_reg;
        bssid_next = bssid_reg;
        phase_next = phase_reg;
        ebl_next   = ebl_reg;
        slen_next  = slen_reg;
        cap_we     = 1'b0;
        cap_wi     = 5'd0;
        first      = (bpos_reg == 12'd0);
        ph         = first ? PH_HEADER : phase_reg;
        ebl_b      = first ? 8'd0 : ebl_reg;
        slen_b     = first ? 6'd0 : slen_reg;
        ok         = 1'b0;
        hdr_end    = 13'd24;
        k          = slen_b - ebl_b[5:0];
        if (is_frame)
        begin
            if (first)
            begin
                fc_next    = data_byte;
                bssid_next = 48'd0;
            end
            if (bpos_reg >= 12'd16 && bpos_reg <= 12'd21)
                bssid_next = {bssid_next[39:0], data_byte};
            ebl_next  = ebl_b;
            slen_next = slen_b;
            phase_next = ph;
            ok = (fc_next[3:2] == 2'b00) && subtype_ok(fc_next);
            hdr_end = ok ? (13'd24 + {8'd0, fixed_len(fc_next)}) : 13'd24;
            unique case (ph)
                PH_HEADER:
                begin
                    if ({1'b0, bpos_reg} + 13'd1 >= hdr_end)
                        phase_next = ok ? PH_TAG : PH_STOP;
                end
                PH_TAG:
                    phase_next = (data_byte == 8'd0) ? PH_SSID_LEN : PH_SKIP_LEN;
                PH_SKIP_LEN:
                begin
                    ebl_next   = data_byte;
                    phase_next = (data_byte == 8'd0) ? PH_TAG : PH_SKIP_BODY;
                end
                PH_SKIP_BODY:
                begin
                    ebl_next = ebl_b - 8'd1;
                    if (ebl_next == 8'd0)
                        phase_next = PH_TAG;
                end
                PH_SSID_LEN:
                begin
                    if (data_byte == 8'd0 || data_byte > 8'd32)
                        phase_next = PH_STOP;
                    else
                    begin
                        slen_next  = data_byte[5:0];
                        ebl_next   = data_byte;
                        phase_next = PH_SSID_BODY;
                    end
                end
                PH_SSID_BODY:
                begin
                    if (k == 6'd0 && data_byte == 8'd0)
                        phase_next = PH_STOP;
                    else
                    begin
                        cap_we   = 1'b1;
                        cap_wi   = k[4:0];
                        ebl_next = ebl_b - 8'd1;
                        if (ebl_next == 8'd0)
                            phase_next = PH_FOUND;
                    end
                end
                default: ;
            endcase
            bpos_next = (bpos_reg < 12'd4095) ? bpos_reg + 12'd1 : bpos_reg;
            if (frame_last)
            begin
                bpos_next  = 12'd0;
                phase_next = PH_HEADER;
                ebl_next   = 8'd0;
            end
        end
    end

    // build the request for the table engine
    always_comb
    begin
        cmd_push    = accept && ((op != OP_FRAME) || frame_last);
        cmd.op      = op;
        cmd.idx     = entry_index;
        cmd.pos     = ssid_position;
        cmd.bssid   = bssid_next;
        cmd.slen    = slen_next;
        cmd.found   = 1'b0;
        cmd.status  = ST_NO_SSID;
        if (op == OP_FRAME)
        begin
            cmd.found = (phase_reg_after() == PH_FOUND);
            if (bpos_after() < 13'd24 || fc_next[3:2] != 2'b00)
                cmd.status = ST_IGNORED;
            else if (!subtype_ok(fc_next))
                cmd.status = ST_BAD_SUB;
            else
                cmd.status = ST_NO_SSID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpos_reg  <= 12'd0;
            fc_reg    <= 8'd0;
            bssid_reg <= 48'd0;
            phase_reg <= PH_HEADER;
            ebl_reg   <= 8'd0;
            slen_reg  <= 6'd0;
        end
        else
        begin
            bpos_reg  <= bpos_next;
            fc_reg    <= fc_next;
            bssid_reg <= bssid_next;
            phase_reg <= phase_next;
            ebl_reg   <= ebl_next;
            slen_reg  <= slen_next;
        end
    end

    // hold captured SSID bytes
    always_ff @(posedge clk)
    begin
        if (cap_we)
            cap_mem[cap_wi] <= data_byte;
    end

    assign cap_byte = cap_mem[cap_idx];

endmodule

>>> sv/ssidl_cmd_fifo.sv
module ssidl_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  ssidl_pkg::cmd_t wdata,
    input  logic            rd,
    output ssidl_pkg::cmd_t rdata,
    output logic            empty,
    output logic            full
);
    import ssidl_pkg::*;

    cmd_t       slot [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign rdata = slot[rp_reg];

    // advance pointers
    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr && !full)
        begin
            wp_next  = ~wp_reg;
            cnt_next = cnt_next + 2'd1;
        end
        if (rd && !empty)
        begin
            rp_next  = ~rp_reg;
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr && !full)
            slot[wp_reg] <= wdata;
    end

endmodule

>>> sv/ssidl_back.sv
module ssidl_back
#(
    parameter int MAX_ENTRIES = ssidl_pkg::MAX_ENTRIES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_avail,
    input  ssidl_pkg::cmd_t cmd_in,
    output logic            cmd_pop,
    output logic [4:0]      cap_idx,
    input  logic [7:0]      cap_byte,
    output logic            busy,
    output logic            empty,
    input  logic            pop,
    output logic [3:0]      status,
    output logic [3:0]      result_index,
    output logic [47:0]     out_bssid,
    output logic [5:0]      out_ssid_length,
    output logic [7:0]      out_ssid_byte,
    output logic [4:0]      entry_count
);
    import ssidl_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;
    localparam int ADDR_W = IDX_W + SSID_POS_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

    bstate_t          st_reg, st_next;
    cmd_t             cmd_reg, cmd_next;
    res_t             res_reg, res_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [4:0]       j_reg, j_next;
    logic             ov_reg, ov_next;
    res_t             ores_reg, ores_next;
    logic [CNT_W-1:0] ocnt_reg, ocnt_next;

    logic [47:0]      bssid_tab [MAX_ENTRIES];
    logic [5:0]       len_tab   [MAX_ENTRIES];
    logic [7:0]       ssid_mem  [MAX_ENTRIES * SSID_BYTES];
    logic [7:0]       rdata_reg;

    logic [IDX_W-1:0]  tab_ridx, tab_widx;
    logic              tab_we;
    logic [47:0]       tab_wbssid;
    logic [5:0]        tab_wlen;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic              mem_we;
    logic [7:0]        mem_wdata;

    logic [CMP_W-1:0]  idx_ext, cnt_ext, k_ext;
    logic [CNT_W-1:0]  kp1;
    logic              out_free;

    assign idx_ext  = CMP_W'(cmd_in.idx);
    assign cnt_ext  = CMP_W'(cnt_reg);
    assign k_ext    = CMP_W'(k_reg);
    assign kp1      = k_reg + CNT_W'(1);
    assign out_free = !ov_reg || pop;
    assign busy     = (st_reg != B_IDLE);
    assign cap_idx  = j_reg;

    // next state and datapath
    always_comb
    begin
        st_next   = st_reg;
        cmd_next  = cmd_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        k_next    = k_reg;
        j_next    = j_reg;
        cmd_pop   = 1'b0;
        ov_next   = ov_reg && !pop;
        ores_next = ores_reg;
        ocnt_next = ocnt_reg;
        unique case (st_reg)
            B_IDLE:
            begin
                if (cmd_avail)
                begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd_in;
                    res_next = '0;
                    st_next  = B_EMIT;
                    unique case (cmd_in.op)
                        OP_FRAME:
                        begin
                            res_next.bssid = cmd_in.bssid;
                            if (!cmd_in.found)
                                res_next.status = cmd_in.status;
                            else if (cmd_in.bssid == BSSID_BCAST)
                            begin
                                res_next.status = ST_BROADCAST;
                                res_next.slen   = cmd_in.slen;
                            end
                            else
                            begin
                                k_next  = '0;
                                st_next = B_SEARCH;
                            end
                        end
                        OP_READ:
                        begin
                            if (idx_ext < cnt_ext)
                                st_next = B_RD_WAIT;
                            else
                            begin
                                res_next.status = ST_BAD_INDEX;
                                res_next.idx    = cmd_in.idx;
                            end
                        end
                        OP_REMOVE:
                        begin
                            res_next.idx = cmd_in.idx;
                            if (idx_ext < cnt_ext)
                            begin
                                k_next = idx_ext[CNT_W-1:0];
                                j_next = 5'd0;
                                if (idx_ext + CMP_W'(1) < cnt_ext)
                                    st_next = B_SHIFT_RD;
                                else
                                begin
                                    cnt_next        = cnt_reg - CNT_W'(1);
                                    res_next.status = ST_REMOVED;
                                end
                            end
                            else
                                res_next.status = ST_REM_BAD;
                        end
                        OP_CLEAR:
                        begin
                            cnt_next        = '0;
                            res_next.status = ST_CLEARED;
                        end
                        default: ;
                    endcase
                end
            end
            B_SEARCH:
            begin
                res_next.slen = cmd_reg.slen;
                if (k_reg == cnt_reg)
                begin
                    if (cnt_reg >= CNT_MAX)
                    begin
                        res_next.status = ST_FULL;
                        st_next         = B_EMIT;
                    end
                    else
                    begin
                        j_next  = 5'd0;
                        st_next = B_COPY;
                    end
                end
                else if (bssid_tab[tab_ridx] == cmd_reg.bssid)
                begin
                    res_next.status = ST_KNOWN;
                    res_next.idx    = k_ext[3:0];
                    st_next         = B_EMIT;
                end
                else
                    k_next = kp1;
            end
            B_COPY:
            begin
                j_next = j_reg + 5'd1;
                if (j_reg == 5'd31)
                begin
                    cnt_next        = cnt_reg + CNT_W'(1);
                    res_next.status = ST_STORED;
                    res_next.idx    = cnt_ext[3:0];
                    st_next         = B_EMIT;
                end
            end
            B_RD_WAIT:
            begin
                res_next.status = ST_READ_OK;
                res_next.idx    = cmd_reg.idx;
                res_next.bssid  = bssid_tab[tab_ridx];
                res_next.slen   = len_tab[tab_ridx];
                res_next.sbyte  = ({1'b0, cmd_reg.pos} < len_tab[tab_ridx]) ?
                                  rdata_reg : 8'd0;
                st_next         = B_EMIT;
            end
            B_SHIFT_RD:
                st_next = B_SHIFT_WR;
            B_SHIFT_WR:
            begin
                j_next  = j_reg + 5'd1;
                st_next = B_SHIFT_RD;
                if (j_reg == 5'd31)
                begin
                    k_next = kp1;
                    if (kp1 + CNT_W'(1) >= cnt_reg)
                    begin
                        cnt_next        = cnt_reg - CNT_W'(1);
                        res_next.status = ST_REMOVED;
                        st_next         = B_EMIT;
                    end
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    ov_next   = 1'b1;
                    ores_next = res_reg;
                    ocnt_next = cnt_reg;
                    st_next   = B_IDLE;
                end
            end
            default:
                st_next = B_IDLE;
        endcase
    end

    // drive table and memory ports
    always_comb
    begin
        tab_ridx   = k_reg[IDX_W-1:0];
        tab_widx   = cnt_reg[IDX_W-1:0];
        tab_we     = 1'b0;
        tab_wbssid = cmd_reg.bssid;
        tab_wlen   = cmd_reg.slen;
        mem_we     = 1'b0;
        mem_waddr  = {cnt_reg[IDX_W-1:0], j_reg};
        mem_wdata  = cap_byte;
        mem_raddr  = {kp1[IDX_W-1:0], j_reg};
        unique case (st_reg)
            B_IDLE:
                mem_raddr = {idx_ext[IDX_W-1:0], cmd_in.pos};
            B_RD_WAIT:
                tab_ridx = IDX_W'(cmd_reg.idx);
            B_COPY:
            begin
                mem_we = 1'b1;
                if (j_reg == 5'd31)
                    tab_we = 1'b1;
            end
            B_SHIFT_WR:
            begin
                tab_ridx  = kp1[IDX_W-1:0];
                tab_widx  = k_reg[IDX_W-1:0];
                mem_we    = 1'b1;
                mem_waddr = {k_reg[IDX_W-1:0], j_reg};
                mem_wdata = rdata_reg;
                if (j_reg == 5'd31)
                begin
                    tab_we     = 1'b1;
                    tab_wbssid = bssid_tab[tab_ridx];
                    tab_wlen   = len_tab[tab_ridx];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= B_IDLE;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        res_reg  <= res_next;
        k_reg    <= k_next;
        j_reg    <= j_next;
        ores_reg <= ores_next;
        ocnt_reg <= ocnt_next;
        if (tab_we)
        begin
            bssid_tab[tab_widx] <= tab_wbssid;
            len_tab[tab_widx]   <= tab_wlen;
        end
    end

    // SSID byte store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ssid_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= ssid_mem[mem_raddr];
    end

    assign empty           = !ov_reg;
    assign status          = ores_reg.status;
    assign result_index    = ores_reg.idx;
    assign out_bssid       = ores_reg.bssid;
    assign out_ssid_length = ores_reg.slen;
    assign out_ssid_byte   = ores_reg.sbyte;
    assign entry_count     = 5'(ocnt_reg);

endmodule

>>> sv/wifi_mgmt_ssid_learner.sv
// Order of work: a request that needs no table work goes straight to its result; a read waits on
// the SSID byte store; a frame searches the table entries in order, and a new one then has its SSID
// copied into the table; a remove shifts each later entry down one slot.
// Throughput: one request at a time through the table engine; input stalls while a request
// is queued or in the engine; frame bytes with no result are taken one per cycle then.
// Reset (rst_n, asynchronous): parser to header phase, table empty, no result pending.
module wifi_mgmt_ssid_learner
#(
    parameter int MAX_ENTRIES = ssidl_pkg::MAX_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    input  logic        frame_last,
    input  logic [3:0]  entry_index,
    input  logic [4:0]  ssid_position,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  status,
    output logic [3:0]  result_index,
    output logic [47:0] out_bssid,
    output logic [5:0]  out_ssid_length,
    output logic [7:0]  out_ssid_byte,
    output logic [4:0]  entry_count
);
    import ssidl_pkg::*;

    logic  accept;
    logic  cmd_push, cmd_pop, q_empty, q_full, busy;
    cmd_t  cmd_w, cmd_r;
    logic [4:0] cap_idx;
    logic [7:0] cap_byte;

    // hold the input while any request is queued or in the engine
    assign full   = !q_empty || q_full || busy;
    assign accept = push && !full;

    ssidl_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .op            (op_t'(op)),
        .data_byte     (data_byte),
        .frame_last    (frame_last),
        .entry_index   (entry_index),
        .ssid_position (ssid_position),
        .cmd_push      (cmd_push),
        .cmd           (cmd_w),
        .cap_idx       (cap_idx),
        .cap_byte      (cap_byte)
    );

    ssidl_cmd_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_push),
        .wdata (cmd_w),
        .rd    (cmd_pop),
        .rdata (cmd_r),
        .empty (q_empty),
        .full  (q_full)
    );

    ssidl_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_avail       (!q_empty),
        .cmd_in          (cmd_r),
        .cmd_pop         (cmd_pop),
        .cap_idx         (cap_idx),
        .cap_byte        (cap_byte),
        .busy            (busy),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .result_index    (result_index),
        .out_bssid       (out_bssid),
        .out_ssid_length (out_ssid_length),
        .out_ssid_byte   (out_ssid_byte),
        .entry_count     (entry_count)
    );

    // table never reports more entries than it holds
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(entry_count) <= MAX_ENTRIES))
        else $error("entry count beyond table size");

    // a queued request always stalls the input
    a_queue_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> full)
        else $error("input open with a request queued");

    // the engine takes a request only from a non-empty queue
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !q_empty)
        else $error("request taken from an empty queue");

    // a fresh result appears only once the engine returns to idle
    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> !busy)
        else $error("result shown while engine busy");

endmodule
